// ----- hdl/cbfr_pkg.sv -----
// Shared constants, types and helpers of the charge box frame receiver.
package cbfr_pkg;

  // Frame geometry
  localparam int MaxParams   = 40;
  localparam int AddrW       = $clog2(MaxParams);
  localparam int CntW        = 6;
  localparam int HeaderBytes = 5;

  // Frame bytes
  localparam logic [7:0] MagicFirst  = 8'h07;
  localparam logic [7:0] MagicSecond = 8'h1E;
  localparam logic [7:0] DirHighMask = 8'hF0;
  localparam logic [7:0] DirLeft     = 8'h01;
  localparam logic [7:0] DirRight    = 8'h02;

  // Earbud side register codes
  localparam logic [1:0] SideLeft  = 2'd1;
  localparam logic [1:0] SideRight = 2'd2;

  // Input command codes
  localparam logic CmdByte    = 1'b0;
  localparam logic CmdTimeout = 1'b1;

  // Result status codes
  localparam logic [2:0] StOk    = 3'd0;
  localparam logic [2:0] StHead  = 3'd1;
  localparam logic [2:0] StParam = 3'd2;
  localparam logic [2:0] StCheck = 3'd3;
  localparam logic [2:0] StDir   = 3'd4;

  // Frame outcome handed from parser to emitter
  typedef struct packed {
    logic            valid;
    logic [2:0]      status;
    logic [7:0]      cmd;
    logic [CntW-1:0] count;
  } job_t;

  // Direction byte against the configured earbud side
  function automatic logic direction_ok(input logic [7:0] dir, input logic [1:0] side);
    logic ok;
    ok = 1'b1;
    if ((dir & DirHighMask) != 8'h00) ok = 1'b0;
    if (dir == DirLeft && side == SideRight) ok = 1'b0;
    if (dir == DirRight && side == SideLeft) ok = 1'b0;
    return ok;
  endfunction

endpackage

// ----- hdl/cbfr_param_ram.sv -----
// Parameter byte store: one write port, one registered read port.
module cbfr_param_ram import cbfr_pkg::*; (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [7:0]       wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [7:0]       rd_data_o
);

  logic [7:0] mem_q [MaxParams];
  logic [7:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- hdl/cbfr_parser.sv -----
// Frame parser: header decode, parameter capture into RAM, check and direction tests.
module cbfr_parser import cbfr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_wdata_i,
  input  logic             accept_i,
  input  logic             command_i,
  input  logic [7:0]       rx_byte_i,
  output logic             wr_en_o,
  output logic [AddrW-1:0] wr_addr_o,
  output logic [7:0]       wr_data_o,
  output job_t             job_o
);

  localparam logic [1:0] PhIdle   = 2'd0;
  localparam logic [1:0] PhHeader = 2'd1;
  localparam logic [1:0] PhParams = 2'd2;

  logic [1:0]      phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      xor_q, xor_d;
  logic            magic_q, magic_d;
  logic [7:0]      dir_q, dir_d;
  logic [7:0]      cmd_q, cmd_d;
  logic [CntW-1:0] len_q, len_d;
  logic [1:0]      side_q;

  // Earbud side register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= 2'd0;
    end else if (cfg_we_i) begin
      side_q <= cfg_wdata_i;
    end
  end

  // Next state per accepted transfer
  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    xor_d     = xor_q;
    magic_d   = magic_q;
    dir_d     = dir_q;
    cmd_d     = cmd_q;
    len_d     = len_q;
    wr_en_o   = 1'b0;
    wr_addr_o = cnt_q[AddrW-1:0];
    wr_data_o = rx_byte_i;
    job_o     = '0;
    if (accept_i) begin
      case (phase_q)
        PhHeader: begin
          if (command_i == CmdTimeout) begin
            job_o   = '{valid: 1'b1, status: StHead, cmd: cmd_q, count: '0};
            phase_d = PhIdle;
          end else begin
            xor_d = xor_q ^ rx_byte_i;
            case (cnt_q)
              6'd1:    magic_d = (rx_byte_i == MagicSecond);
              6'd2:    dir_d   = rx_byte_i;
              6'd3:    cmd_d   = rx_byte_i;
              default: ;
            endcase
            cnt_d = cnt_q + 6'd1;
            // fifth header byte is the length: judge the header now
            if (cnt_q == CntW'(HeaderBytes - 1)) begin
              if (!magic_q || rx_byte_i > 8'(MaxParams)) begin
                job_o   = '{valid: 1'b1, status: StHead, cmd: cmd_q, count: '0};
                phase_d = PhIdle;
              end else begin
                phase_d = PhParams;
                cnt_d   = '0;
                len_d   = rx_byte_i[CntW-1:0];
              end
            end
          end
        end
        PhParams: begin
          if (command_i == CmdTimeout) begin
            job_o   = '{valid: 1'b1, status: StParam, cmd: cmd_q, count: '0};
            phase_d = PhIdle;
          end else if (cnt_q < len_q) begin
            wr_en_o = 1'b1;
            xor_d   = xor_q ^ rx_byte_i;
            cnt_d   = cnt_q + 6'd1;
          end else if (xor_q != rx_byte_i) begin
            job_o   = '{valid: 1'b1, status: StCheck, cmd: cmd_q, count: '0};
            phase_d = PhIdle;
          end else if (!direction_ok(dir_q, side_q)) begin
            job_o   = '{valid: 1'b1, status: StDir, cmd: cmd_q, count: '0};
            phase_d = PhIdle;
          end else begin
            job_o   = '{valid: 1'b1, status: StOk, cmd: cmd_q, count: len_q};
            phase_d = PhIdle;
          end
        end
        default: begin
          // idle: hunt for the first magic byte
          phase_d = PhIdle;
          if (command_i == CmdByte && rx_byte_i == MagicFirst) begin
            phase_d = PhHeader;
            cnt_d   = 6'd1;
            xor_d   = MagicFirst;
            magic_d = 1'b0;
            dir_d   = 8'h00;
            cmd_d   = 8'h00;
            len_d   = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      cnt_q   <= '0;
      xor_q   <= 8'h00;
      magic_q <= 1'b0;
      dir_q   <= 8'h00;
      cmd_q   <= 8'h00;
      len_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      xor_q   <= xor_d;
      magic_q <= magic_d;
      dir_q   <= dir_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
    end
  end

endmodule

// ----- hdl/cbfr_emitter.sv -----
// Result emitter: turns a frame outcome into a status result or a run read from RAM.
module cbfr_emitter import cbfr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  job_t             job_i,
  output logic             busy_o,
  output logic             rd_en_o,
  output logic [AddrW-1:0] rd_addr_o,
  input  logic [7:0]       rd_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [2:0]       status_o,
  output logic [7:0]       cmd_code_o,
  output logic [CntW-1:0]  param_count_o,
  output logic [CntW-1:0]  param_index_o,
  output logic [7:0]       param_value_o,
  output logic             last_o
);

  localparam logic [1:0] EIdle   = 2'd0;
  localparam logic [1:0] ESingle = 2'd1;
  localparam logic [1:0] ERead   = 2'd2;
  localparam logic [1:0] ELoad   = 2'd3;

  logic [1:0]      st_q, st_d;
  logic [2:0]      jst_q, jst_d;
  logic [7:0]      jcmd_q, jcmd_d;
  logic [CntW-1:0] jcnt_q, jcnt_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            ov_q, ov_d;
  logic            load;
  logic            is_last;
  logic [2:0]      o_st_q, o_st_d;
  logic [7:0]      o_cmd_q, o_cmd_d;
  logic [CntW-1:0] o_cnt_q, o_cnt_d;
  logic [CntW-1:0] o_idx_q, o_idx_d;
  logic [7:0]      o_val_q, o_val_d;
  logic            o_last_q, o_last_d;

  assign busy_o    = (st_q != EIdle);
  assign rd_addr_o = idx_q[AddrW-1:0];
  assign is_last   = (idx_q == jcnt_q - 6'd1);

  // Sequencer: one status load, or one RAM read then one output load per parameter
  always_comb begin
    st_d     = st_q;
    jst_d    = jst_q;
    jcmd_d   = jcmd_q;
    jcnt_d   = jcnt_q;
    idx_d    = idx_q;
    rd_en_o  = 1'b0;
    load     = 1'b0;
    o_st_d   = o_st_q;
    o_cmd_d  = o_cmd_q;
    o_cnt_d  = o_cnt_q;
    o_idx_d  = o_idx_q;
    o_val_d  = o_val_q;
    o_last_d = o_last_q;
    case (st_q)
      EIdle: begin
        if (job_i.valid) begin
          jst_d  = job_i.status;
          jcmd_d = job_i.cmd;
          jcnt_d = job_i.count;
          idx_d  = '0;
          st_d   = (job_i.status == StOk && job_i.count != '0) ? ERead : ESingle;
        end
      end
      ESingle: begin
        if (!ov_q || !out_stall_i) begin
          load     = 1'b1;
          o_st_d   = jst_q;
          o_cmd_d  = jcmd_q;
          o_cnt_d  = '0;
          o_idx_d  = '0;
          o_val_d  = 8'h00;
          o_last_d = 1'b1;
          st_d     = EIdle;
        end
      end
      ERead: begin
        rd_en_o = 1'b1;
        st_d    = ELoad;
      end
      ELoad: begin
        if (!ov_q || !out_stall_i) begin
          load     = 1'b1;
          o_st_d   = StOk;
          o_cmd_d  = jcmd_q;
          o_cnt_d  = jcnt_q;
          o_idx_d  = idx_q;
          o_val_d  = rd_data_i;
          o_last_d = is_last;
          idx_d    = idx_q + 6'd1;
          st_d     = is_last ? EIdle : ERead;
        end
      end
      default: st_d = EIdle;
    endcase
  end

  // Output register valid
  always_comb begin
    ov_d = ov_q;
    if (load) begin
      ov_d = 1'b1;
    end else if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= EIdle;
      idx_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      idx_q <= idx_d;
      ov_q  <= ov_d;
    end
  end

  // Job and output payload
  always_ff @(posedge clk_i) begin
    jst_q    <= jst_d;
    jcmd_q   <= jcmd_d;
    jcnt_q   <= jcnt_d;
    o_st_q   <= o_st_d;
    o_cmd_q  <= o_cmd_d;
    o_cnt_q  <= o_cnt_d;
    o_idx_q  <= o_idx_d;
    o_val_q  <= o_val_d;
    o_last_q <= o_last_d;
  end

  assign out_valid_o   = ov_q;
  assign status_o      = o_st_q;
  assign cmd_code_o    = o_cmd_q;
  assign param_count_o = o_cnt_q;
  assign param_index_o = o_idx_q;
  assign param_value_o = o_val_q;
  assign last_o        = o_last_q;

endmodule

// ----- hdl/charge_box_frame_receiver_top.sv -----
// Throughput: one input transfer per cycle while no results are being produced.
// A good frame of n parameters emits each result by a RAM read, then a load,
// stalling input until its last result is loaded; an error or empty frame stalls
// input until its single status result is loaded.
// Reset (rst_ni, asynchronous, active low) returns to idle with device side 0;
// the parameter RAM is not cleared, only bytes of the current frame are read back.
module charge_box_frame_receiver_top import cbfr_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            command_i,
  input  logic [7:0]      rx_byte_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [2:0]      status_o,
  output logic [7:0]      cmd_code_o,
  output logic [CntW-1:0] param_count_o,
  output logic [CntW-1:0] param_index_o,
  output logic [7:0]      param_value_o,
  output logic            last_o
);

  logic             accept;
  logic             busy;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [7:0]       wr_data;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic [7:0]       rd_data;
  job_t             job;

  // Input held off while a frame outcome is being emitted
  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;

  cbfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .command_i   (command_i),
    .rx_byte_i   (rx_byte_i),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .job_o       (job)
  );

  cbfr_param_ram u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  cbfr_emitter u_emitter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (job),
    .busy_o        (busy),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .rd_data_i     (rd_data),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .cmd_code_o    (cmd_code_o),
    .param_count_o (param_count_o),
    .param_index_o (param_index_o),
    .param_value_o (param_value_o),
    .last_o        (last_o)
  );

endmodule

// ----- hdl/cbfr_checker.sv -----
// Port-level checks of the frame receiver results, bound to the top level.
module cbfr_checker import cbfr_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_i,
  input logic            out_stall_i,
  input logic [2:0]      status_i,
  input logic [CntW-1:0] param_count_i,
  input logic [CntW-1:0] param_index_i,
  input logic [7:0]      param_value_i,
  input logic            last_i
);

  // A stalled result stays and holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(param_index_i)
      && $stable(param_value_i) && $stable(status_i))
    else $error("stalled result changed");

  // Error results are single, carry no parameters
  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != StOk |-> last_i && param_count_i == '0
      && param_index_i == '0 && param_value_i == 8'h00)
    else $error("error result not a lone status");

  // Within a run, last marks exactly the final index
  a_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && param_count_i != '0 |->
      (last_i == (param_index_i == param_count_i - 6'd1))
      && param_count_i <= CntW'(MaxParams))
    else $error("run last flag or count wrong");

  // After a transfer of a non-final run result, the next result carries the next index
  a_run_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_stall_i && !last_i && out_valid_i ##1 out_valid_i |->
      param_index_i == $past(param_index_i) + 6'd1)
    else $error("run index did not advance by one");

endmodule

bind charge_box_frame_receiver_top cbfr_checker u_cbfr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .status_i      (status_o),
  .param_count_i (param_count_o),
  .param_index_i (param_index_o),
  .param_value_i (param_value_o),
  .last_i        (last_o)
);

// ----- test/tb_top.sv -----
// Self-checking testbench for the charge box frame receiver: driver, monitor and frame predictor.
`timescale 1ns / 1ps

module tb_top;
  import cbfr_pkg::*;

  // One UART event offered to the receiver
  typedef struct {
    logic       tmo;
    logic [7:0] data;
  } uart_xfer_t;

  // One result transfer of the receiver
  typedef struct {
    logic [2:0]      status;
    logic [7:0]      cmd;
    logic [CntW-1:0] count;
    logic [CntW-1:0] index;
    logic [7:0]      value;
    logic            last;
  } frame_result_t;

  typedef enum logic [1:0] {PhIdle, PhHeader, PhParams} parse_phase_e;

  typedef enum int {FltNone, FltMagic, FltLength, FltHeadTmo, FltParamTmo,
                    FltCheck, FltCut} frame_fault_e;

  localparam int SettleCycles = 100;
  localparam int HoldCycles   = 400;

  // DUT ports, all known from time zero
  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            cfg_we_i    = 1'b0;
  logic [1:0]      cfg_wdata_i = 2'd0;
  logic            in_valid_i  = 1'b0;
  logic            in_stall_o;
  logic            command_i   = CmdByte;
  logic [7:0]      rx_byte_i   = 8'h00;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  logic [2:0]      status_o;
  logic [7:0]      cmd_code_o;
  logic [CntW-1:0] param_count_o;
  logic [CntW-1:0] param_index_o;
  logic [7:0]      param_value_o;
  logic            last_o;

  // Stimulus and expectation stores
  uart_xfer_t    uart_tx_q[$];
  uart_xfer_t    tx_head;
  frame_result_t frame_results_q[$];
  frame_result_t want;

  // Predictor state
  parse_phase_e rx_phase    = PhIdle;
  int           rx_pos      = 0;
  logic [7:0]   rx_xor      = 8'h00;
  logic         rx_magic_ok = 1'b0;
  logic [7:0]   rx_dir      = 8'h00;
  logic [7:0]   rx_cmd      = 8'h00;
  logic [7:0]   rx_len      = 8'h00;
  logic [7:0]   rx_store [MaxParams];
  logic [1:0]   rx_side     = 2'd0;

  // Run control and statistics
  int err_cnt       = 0;
  int n_xfers       = 0;
  int n_results     = 0;
  int n_items       = 0;
  int n_good_frames = 0;
  int status_seen [5];
  int tx_idle_pct   = 33;
  int rx_idle_pct   = 33;
  int rx_hold_req_n = 0;
  int rx_hold_seen  = 0;
  int rx_hold_left  = 0;

  charge_box_frame_receiver_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .cmd_code_o    (cmd_code_o),
    .param_count_o (param_count_o),
    .param_index_o (param_index_o),
    .param_value_o (param_value_o),
    .last_o        (last_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Run limit
  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Error outcome: single status result, parser back to idle
  function automatic void frame_error(input logic [2:0] st);
    frame_result_t r;
    r = '{status: st, cmd: rx_cmd, count: '0, index: '0, value: 8'h00, last: 1'b1};
    frame_results_q.push_back(r);
    rx_phase = PhIdle;
  endfunction

  function automatic logic side_accepts(input logic [7:0] dir);
    if (dir[7:4] != 4'h0) return 1'b0;
    if (dir == DirLeft && rx_side == SideRight) return 1'b0;
    if (dir == DirRight && rx_side == SideLeft) return 1'b0;
    return 1'b1;
  endfunction

  // Advance the frame parser by one accepted transfer
  function automatic void decode_rx_transfer(input logic tmo, input logic [7:0] b);
    frame_result_t r;
    case (rx_phase)
      PhHeader: begin
        if (tmo) begin
          frame_error(StHead);
          return;
        end
        rx_xor ^= b;
        case (rx_pos)
          1: rx_magic_ok = (b == MagicSecond);
          2: rx_dir = b;
          3: rx_cmd = b;
          default: rx_len = b;
        endcase
        rx_pos++;
        if (rx_pos >= HeaderBytes) begin
          if (!rx_magic_ok || rx_len > MaxParams) begin
            frame_error(StHead);
          end else begin
            rx_phase = PhParams;
            rx_pos   = 0;
          end
        end
      end
      PhParams: begin
        if (tmo) begin
          frame_error(StParam);
          return;
        end
        if (rx_pos < rx_len) begin
          rx_store[rx_pos] = b;
          rx_xor ^= b;
          rx_pos++;
          return;
        end
        // check byte: checksum first, then direction
        if (rx_xor != b) begin
          frame_error(StCheck);
          return;
        end
        if (!side_accepts(rx_dir)) begin
          frame_error(StDir);
          return;
        end
        rx_phase = PhIdle;
        if (rx_len == 8'd0) begin
          r = '{status: StOk, cmd: rx_cmd, count: '0, index: '0, value: 8'h00, last: 1'b1};
          frame_results_q.push_back(r);
        end else begin
          for (int i = 0; i < rx_len; i++) begin
            r.status = StOk;
            r.cmd    = rx_cmd;
            r.count  = rx_len[CntW-1:0];
            r.index  = i[CntW-1:0];
            r.value  = rx_store[i];
            r.last   = (i == rx_len - 1);
            frame_results_q.push_back(r);
          end
        end
      end
      default: begin
        rx_phase = PhIdle;
        if (!tmo && b == MagicFirst) begin
          rx_phase    = PhHeader;
          rx_pos      = 1;
          rx_xor      = MagicFirst;
          rx_magic_ok = 1'b0;
          rx_dir      = 8'h00;
          rx_cmd      = 8'h00;
          rx_len      = 8'h00;
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued transfers, predicts on every accepted one
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        decode_rx_transfer(command_i, rx_byte_i);
        n_xfers++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (uart_tx_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          tx_head = uart_tx_q.pop_front();
          in_valid_i <= 1'b1;
          command_i  <= tx_head.tmo;
          rx_byte_i  <= tx_head.data;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks result transfers, drives the output stall
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (frame_results_q.size() == 0) begin
        $display("%0t ns: result with nothing expected, actual status %0d cmd %0d index %0d",
                 $time, status_o, cmd_code_o, param_index_o);
        err_cnt++;
      end else begin
        want = frame_results_q.pop_front();
        check_field("status", want.status, status_o);
        check_field("cmd_code", want.cmd, cmd_code_o);
        check_field("param_count", want.count, param_count_o);
        check_field("param_index", want.index, param_index_o);
        check_field("param_value", want.value, param_value_o);
        check_field("last", want.last, last_o);
        if (want.last) begin
          if (want.status == StOk) n_good_frames++;
          else status_seen[want.status]++;
        end
      end
    end
    // long hold-off on request, else random stalls
    if (rx_hold_seen != rx_hold_req_n) begin
      rx_hold_seen = rx_hold_req_n;
      rx_hold_left = HoldCycles;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic uart_xfer_t data_xfer(input logic [7:0] b);
    uart_xfer_t x;
    x.tmo  = CmdByte;
    x.data = b;
    return x;
  endfunction

  function automatic uart_xfer_t tmo_xfer();
    uart_xfer_t x;
    x.tmo  = CmdTimeout;
    x.data = 8'($urandom_range(255));
    return x;
  endfunction

  // Build one frame, optionally damaged, and queue it
  task automatic add_frame(input logic [7:0] dir, input logic [7:0] cmd, input int len,
                           input frame_fault_e fault);
    uart_xfer_t seq[$];
    logic [7:0] magic2;
    logic [7:0] chk;
    logic [7:0] p;
    int keep;
    magic2 = MagicSecond;
    if (fault == FltMagic) begin
      magic2 = 8'($urandom_range(255));
      if (magic2 == MagicSecond) magic2 = ~MagicSecond;
    end
    seq.push_back(data_xfer(MagicFirst));
    seq.push_back(data_xfer(magic2));
    seq.push_back(data_xfer(dir));
    seq.push_back(data_xfer(cmd));
    seq.push_back(data_xfer(len[7:0]));
    if (fault != FltMagic && fault != FltLength) begin
      for (int i = 0; i < len; i++) begin
        // an embedded start byte is plain data
        p = ($urandom_range(7) == 0) ? MagicFirst : 8'($urandom_range(255));
        seq.push_back(data_xfer(p));
      end
      chk = 8'h00;
      foreach (seq[i]) chk ^= seq[i].data;
      if (fault == FltCheck) chk ^= 8'($urandom_range(1, 255));
      seq.push_back(data_xfer(chk));
    end
    case (fault)
      FltHeadTmo: keep = $urandom_range(1, HeaderBytes - 1);
      FltParamTmo: keep = $urandom_range(HeaderBytes, HeaderBytes + len);
      FltCut: keep = $urandom_range(1, seq.size() - 1);
      default: keep = seq.size();
    endcase
    while (seq.size() > keep) void'(seq.pop_back());
    if (fault == FltHeadTmo || fault == FltParamTmo) seq.push_back(tmo_xfer());
    n_items += seq.size();
    foreach (seq[i]) uart_tx_q.push_back(seq[i]);
  endtask

  // Bytes other than a frame start, and stray timeouts
  task automatic add_noise();
    logic [7:0] b;
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(1)) begin
        uart_tx_q.push_back(tmo_xfer());
      end else begin
        b = 8'($urandom_range(255));
        if (b == MagicFirst) b = ~b;
        uart_tx_q.push_back(data_xfer(b));
      end
      n_items++;
    end
  endtask

  function automatic logic [7:0] pick_dir();
    if ($urandom_range(99) < 80) return 8'($urandom_range(3));
    return 8'($urandom_range(255));
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(0, 4);
    if (r < 85) return $urandom_range(5, 12);
    if (r < 95) return $urandom_range(13, MaxParams - 1);
    return MaxParams;
  endfunction

  function automatic int pick_bad_len();
    case ($urandom_range(3))
      0: return MaxParams + 1;
      1: return 255;
      default: return $urandom_range(MaxParams + 1, 255);
    endcase
  endfunction

  // Mostly good frames, the rest damaged frames and noise
  task automatic add_random_traffic(input int count);
    int target;
    int r;
    target = n_items + count;
    while (n_items < target) begin
      r = $urandom_range(99);
      if (r < 68) add_frame(pick_dir(), 8'($urandom_range(255)), pick_len(), FltNone);
      else if (r < 73) add_frame(pick_dir(), 8'($urandom_range(255)), pick_len(), FltMagic);
      else if (r < 77) add_frame(pick_dir(), 8'($urandom_range(255)), pick_bad_len(), FltLength);
      else if (r < 82) add_frame(pick_dir(), 8'($urandom_range(255)), pick_len(), FltHeadTmo);
      else if (r < 87) add_frame(pick_dir(), 8'($urandom_range(255)), pick_len(), FltParamTmo);
      else if (r < 92) add_frame(pick_dir(), 8'($urandom_range(255)), pick_len(), FltCheck);
      else if (r < 95) add_frame(pick_dir(), 8'($urandom_range(255)), pick_len(), FltCut);
      else add_noise();
    end
    // close any frame left open
    uart_tx_q.push_back(tmo_xfer());
  endtask

  // Sender holds back until every expected result has arrived
  task automatic wait_drained();
    do @(negedge clk_i);
    while (uart_tx_q.size() > 0 || in_valid_i || frame_results_q.size() > 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_side(input logic [1:0] side);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= side;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    rx_side = side;
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  logic [1:0] side_plan [6];

  initial begin
    side_plan = '{SideLeft, SideRight, 2'd3, 2'd0, SideRight, SideLeft};
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: idle timeout and idle byte, empty frame with zero fields,
    // header timeout, bad second magic, oversized length, bad direction
    uart_tx_q.push_back(tmo_xfer());
    uart_tx_q.push_back(data_xfer(8'hFF));
    add_frame(8'h00, 8'h00, 0, FltNone);
    add_frame(8'h00, 8'hFF, 1, FltNone);
    uart_tx_q.push_back(data_xfer(MagicFirst));
    uart_tx_q.push_back(tmo_xfer());
    add_frame(8'h01, 8'h5A, 3, FltMagic);
    add_frame(8'h02, 8'hA5, MaxParams + 1, FltLength);
    add_frame(8'hF0, 8'h3C, 0, FltNone);
    wait_drained();

    // Random phases over all side settings
    for (int ph = 0; ph < 6; ph++) begin
      write_side(side_plan[ph]);
      tx_idle_pct = (ph == 3) ? 0 : 33;
      rx_idle_pct = (ph == 3) ? 0 : 33;
      if (ph == 1) begin
        // receiver holds off while long good frames keep arriving
        rx_hold_req_n++;
        repeat (4) add_frame(8'h00, 8'($urandom_range(255)), $urandom_range(15, MaxParams),
                             FltNone);
      end
      add_random_traffic((ph == 1) ? 15 : 55);
      wait_drained();
    end

    $display("Covered %0d input transfers and %0d results over device sides 0 to 3.",
             n_xfers, n_results);
    $display("Good frames %0d; errors: header %0d, timeout %0d, check %0d, direction %0d.",
             n_good_frames, status_seen[StHead], status_seen[StParam],
             status_seen[StCheck], status_seen[StDir]);
    if (err_cnt == 0 && frame_results_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
